FILE: src/acdd_pkg.sv
// ----------------------------------------------------------------------------
// acdd_pkg
// Shared widths, constants, codes and types of the Ackermann differential
// drive block: tangent table, register indexes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package acdd_pkg;

  // field widths
  localparam int BASE_W     = 15;
  localparam int ANG_W      = 7;
  localparam int DUTY_W     = 14;
  localparam int ALIM_W     = 6;
  localparam int GEOM_W     = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // default steering span in degrees that maps to the full servo swing
  localparam int ANGLE_SPAN_DEF = 45;

  // shared multiplier
  localparam int MUL_W  = 24;
  localparam int PROD_W = 2 * MUL_W;

  // shared divider: dividend and divisor widths
  localparam int DVD_W = 27;
  localparam int DVS_W = 10;

  // ratio r in Q2.16, magnitude saturates just below 4.0
  localparam int FRAC_W = 16;
  localparam int RQ_W   = 18;
  localparam logic [RQ_W-1:0] R_MAX = '1;

  // wheel speed after dropping the fraction
  localparam int SP_W = PROD_W - FRAC_W;

  // magnitude of servo span times clamped angle
  localparam int SRV_PROD_W = 20;

  // servo duty intermediate, signed
  localparam int SDUTY_W = SRV_PROD_W + 2;

  // tangent table, Q2.14, whole degrees 0..64
  localparam int TAN_W    = 16;
  localparam int TAN_LAST = 64;
  localparam int TAN_IDX_W = 7;
  localparam logic [TAN_W-1:0] TAN_Q14 [TAN_LAST+1] = '{
    16'd0,     16'd286,   16'd572,   16'd859,   16'd1146,  16'd1433,  16'd1722,
    16'd2012,  16'd2303,  16'd2595,  16'd2889,  16'd3185,  16'd3483,  16'd3783,
    16'd4085,  16'd4390,  16'd4698,  16'd5009,  16'd5323,  16'd5641,  16'd5963,
    16'd6289,  16'd6620,  16'd6955,  16'd7295,  16'd7640,  16'd7991,  16'd8348,
    16'd8712,  16'd9082,  16'd9459,  16'd9845,  16'd10238, 16'd10640, 16'd11051,
    16'd11472, 16'd11904, 16'd12346, 16'd12801, 16'd13268, 16'd13748, 16'd14242,
    16'd14752, 16'd15278, 16'd15822, 16'd16384, 16'd16966, 16'd17570, 16'd18196,
    16'd18848, 16'd19526, 16'd20233, 16'd20971, 16'd21742, 16'd22551, 16'd23399,
    16'd24290, 16'd25229, 16'd26220, 16'd27268, 16'd28378, 16'd29557, 16'd30814,
    16'd32155, 16'd33592
  };

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SERVO_CENTER = 3'd0,
    REG_SERVO_LEFT   = 3'd1,
    REG_SERVO_RIGHT  = 3'd2,
    REG_SERVO_ANGLE  = 3'd3,
    REG_MOTOR_LIMIT  = 3'd4,
    REG_TRACK_WIDTH  = 3'd5,
    REG_WHEEL_BASE   = 3'd6
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SERVO_MUL,
    ST_SERVO_RECIP,
    ST_SERVO_FIN,
    ST_RATIO_MUL,
    ST_RATIO_DIV,
    ST_RATIO_WAIT,
    ST_LEFT_MUL,
    ST_LEFT_FIN,
    ST_RIGHT_MUL,
    ST_RIGHT_FIN,
    ST_OUT
  } state_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // one wheel: direction and duty magnitude
  typedef struct packed {
    logic              dir;
    logic [DUTY_W-1:0] pwm;
  } wheel_t;

endpackage

`default_nettype wire

FILE: src/acdd_if.sv
// ----------------------------------------------------------------------------
// acdd channel interfaces
// Valid/ready channels of the block: steering commands in, drive results
// out, and the configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface acdd_cmd_if import acdd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [BASE_W-1:0] speed_cmd;
  logic signed [ANG_W-1:0]  steer_angle;

  modport source (output valid, output speed_cmd, output steer_angle, input ready);
  modport sink   (input valid, input speed_cmd, input steer_angle, output ready);
endinterface

interface acdd_res_if import acdd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] servo_duty;
  logic              left_dir;
  logic [DUTY_W-1:0] left_pwm;
  logic              right_dir;
  logic [DUTY_W-1:0] right_pwm;

  modport source (output valid, output servo_duty, output left_dir, output left_pwm,
                  output right_dir, output right_pwm, input ready);
  modport sink   (input valid, input servo_duty, input left_dir, input left_pwm,
                  input right_dir, input right_pwm, output ready);
endinterface

interface acdd_cfg_if import acdd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/acdd_div.sv
// ----------------------------------------------------------------------------
// acdd_div
// Unsigned radix-2 restoring divider, one quotient bit per cycle; done
// pulses for one cycle with the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module acdd_div import acdd_pkg::*; #(
  parameter int DVD_W_P = DVD_W,
  parameter int DVS_W_P = DVS_W
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [DVD_W_P-1:0] dividend,
  input  wire logic [DVS_W_P-1:0] divisor,
  output logic [DVD_W_P-1:0]      quotient,
  output div_stat_t               stat
);

  localparam int CNT_W = $clog2(DVD_W_P + 1);

  logic [DVD_W_P-1:0] quo;
  logic [DVS_W_P-1:0] rem;
  logic [DVS_W_P-1:0] dvs;
  logic [CNT_W-1:0]   cnt;
  logic               done;

  logic [DVS_W_P:0]   shifted;
  logic [DVS_W_P:0]   diff;
  logic               fits;

  // one trial subtract per cycle
  always_comb begin
    shifted = {rem, quo[DVD_W_P-1]};
    diff    = shifted - {1'b0, dvs};
    fits    = (shifted >= {1'b0, dvs});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_W'(1));
      if (start) begin
        cnt <= CNT_W'(DVD_W_P);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (cnt != '0) begin
      quo <= {quo[DVD_W_P-2:0], fits};
      rem <= fits ? diff[DVS_W_P-1:0] : shifted[DVS_W_P-1:0];
    end
  end

  assign quotient  = quo;
  assign stat.busy = (cnt != '0);
  assign stat.done = done;

endmodule

`default_nettype wire

FILE: src/ackermann_differential_drive_top.sv
// ----------------------------------------------------------------------------
// ackermann_differential_drive_top
// Steering servo duty and differential rear wheel drive from one command.
// ----------------------------------------------------------------------------
// Each command transfer yields one result. The block works on one command at
// a time, taking no new command before the last result is loaded. The work is
// one pass through the shared 27-step radix-2 divider for the wheel ratio
// plus steps around it: five on the shared 24x24 multiplier (servo span
// product, its reciprocal scaling by the steering span, the ratio product and
// both wheel products) and five for servo clamp, divider start, the two wheel
// clamps and the output load. A finished result sits in an output register,
// so the next command is taken while it waits. Configuration registers may be
// written whenever the block is idle; the configuration channel is always
// ready.
`default_nettype none

module ackermann_differential_drive_top import acdd_pkg::*; #(
  parameter int ANGLE_SPAN = ANGLE_SPAN_DEF
) (
  input wire logic clk,
  input wire logic rst,
  acdd_cmd_if.sink   cmd,
  acdd_res_if.source res,
  acdd_cfg_if.sink   cfg
);

  localparam logic signed [MUL_W-1:0]  ONE_Q     = MUL_W'(1 << FRAC_W);
  localparam logic signed [PROD_W-1:0] ROUND_ADJ = PROD_W'((1 << FRAC_W) - 1);

  // reciprocal of the steering span, exact for magnitudes below 2**SRV_PROD_W
  localparam int     RECIP_SH = SRV_PROD_W + $clog2(ANGLE_SPAN);
  localparam longint RECIP_M  = ((longint'(1) << RECIP_SH) + longint'(ANGLE_SPAN) - 1)
                                / longint'(ANGLE_SPAN);

  // configuration registers
  logic [DUTY_W-1:0] center_r;
  logic [DUTY_W-1:0] left_lim_r;
  logic [DUTY_W-1:0] right_lim_r;
  logic [ALIM_W-1:0] ang_lim_r;
  logic [DUTY_W-1:0] motor_lim_r;
  logic [GEOM_W-1:0] track_r;
  logic [GEOM_W-1:0] wbase_r;

  // sequencer
  state_t state;
  state_t state_next;

  // command and working registers
  logic signed [BASE_W-1:0] base_r;
  logic signed [ANG_W-1:0]  ang_r;
  logic signed [PROD_W-1:0] prod;
  logic                     servo_neg;
  logic [DUTY_W-1:0]        servo_duty_r;
  logic signed [RQ_W:0]     ratio_r;
  logic                     left_dir_held;
  logic                     right_dir_held;
  logic [DUTY_W-1:0]        left_pwm_r;
  logic [DUTY_W-1:0]        right_pwm_r;

  // output register
  logic              res_valid;
  logic [DUTY_W-1:0] res_servo;
  logic              res_ldir;
  logic [DUTY_W-1:0] res_lpwm;
  logic              res_rdir;
  logic [DUTY_W-1:0] res_rpwm;

  // control outputs of the sequencer
  logic cmd_ready;
  logic div_start;
  logic mul_en;
  logic res_load;

  // shared units
  logic signed [MUL_W-1:0] mul_a;
  logic signed [MUL_W-1:0] mul_b;
  logic [DVD_W-1:0]        div_dvd;
  logic [DVS_W-1:0]        div_dvs;
  logic [DVD_W-1:0]        div_quo;
  div_stat_t               div_stat;

  // combinational helpers
  logic signed [ANG_W:0]    ang_ext;
  logic signed [ANG_W:0]    lim_s;
  logic signed [ANG_W:0]    servo_ang;
  logic signed [DUTY_W:0]   servo_span;
  logic [ANG_W:0]           ang_mag;
  logic [TAN_IDX_W-1:0]     tan_idx;
  logic signed [PROD_W-1:0] prod_abs;
  logic signed [SDUTY_W-1:0] q_s;
  logic signed [SDUTY_W-1:0] duty;
  logic signed [SDUTY_W-1:0] left_s;
  logic signed [SDUTY_W-1:0] right_s;
  logic [DUTY_W-1:0]        duty_clamped;
  logic [RQ_W-1:0]          rq;
  logic signed [RQ_W:0]     rq_s;
  wheel_t                   wheel;

  // clamp a wheel speed, split it into direction and magnitude
  function automatic wheel_t wheel_drive(input logic signed [PROD_W-1:0] p,
                                         input logic [DUTY_W-1:0] lim,
                                         input logic held);
    logic signed [PROD_W-1:0] adj;
    logic signed [SP_W-1:0]   sp;
    logic signed [SP_W-1:0]   lim_w;
    logic signed [SP_W-1:0]   s;
    logic signed [SP_W-1:0]   s_neg;
    wheel_t                   w;
    adj   = p[PROD_W-1] ? p + ROUND_ADJ : p;
    sp    = adj[PROD_W-1:FRAC_W];
    lim_w = SP_W'(lim);
    if (sp > lim_w) begin
      s = lim_w;
    end else if (sp < -lim_w) begin
      s = -lim_w;
    end else begin
      s = sp;
    end
    s_neg = -s;
    if (s > 0) begin
      w.dir = 1'b0;
      w.pwm = s[DUTY_W-1:0];
    end else if (s < 0) begin
      w.dir = 1'b1;
      w.pwm = s_neg[DUTY_W-1:0];
    end else begin
      w.dir = held;
      w.pwm = '0;
    end
    return w;
  endfunction

  // configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_r    <= DUTY_W'(750);
      left_lim_r  <= DUTY_W'(500);
      right_lim_r <= DUTY_W'(1000);
      ang_lim_r   <= ALIM_W'(45);
      motor_lim_r <= DUTY_W'(8000);
      track_r     <= GEOM_W'(160);
      wbase_r     <= GEOM_W'(200);
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_SERVO_CENTER: center_r    <= cfg.data[DUTY_W-1:0];
        REG_SERVO_LEFT:   left_lim_r  <= cfg.data[DUTY_W-1:0];
        REG_SERVO_RIGHT:  right_lim_r <= cfg.data[DUTY_W-1:0];
        REG_SERVO_ANGLE:  ang_lim_r   <= cfg.data[ALIM_W-1:0];
        REG_MOTOR_LIMIT:  motor_lim_r <= cfg.data[DUTY_W-1:0];
        REG_TRACK_WIDTH:  track_r     <= cfg.data[GEOM_W-1:0];
        REG_WHEEL_BASE:   wbase_r     <= cfg.data[GEOM_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:        if (cmd.valid) state_next = ST_SERVO_MUL;
      ST_SERVO_MUL:   state_next = ST_SERVO_RECIP;
      ST_SERVO_RECIP: state_next = ST_SERVO_FIN;
      ST_SERVO_FIN:   state_next = ST_RATIO_MUL;
      ST_RATIO_MUL:   state_next = ST_RATIO_DIV;
      ST_RATIO_DIV:   state_next = ST_RATIO_WAIT;
      ST_RATIO_WAIT:  if (div_stat.done) state_next = ST_LEFT_MUL;
      ST_LEFT_MUL:    state_next = ST_LEFT_FIN;
      ST_LEFT_FIN:    state_next = ST_RIGHT_MUL;
      ST_RIGHT_MUL:   state_next = ST_RIGHT_FIN;
      ST_RIGHT_FIN:   state_next = ST_OUT;
      ST_OUT:         if (!res_valid || res.ready) state_next = ST_IDLE;
      default:        state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    cmd_ready = 1'b0;
    div_start = 1'b0;
    mul_en    = 1'b0;
    res_load  = 1'b0;
    case (state)
      ST_IDLE:        cmd_ready = 1'b1;
      ST_SERVO_MUL:   mul_en    = 1'b1;
      ST_SERVO_RECIP: mul_en    = 1'b1;
      ST_RATIO_MUL:   mul_en    = 1'b1;
      ST_RATIO_DIV:   div_start = 1'b1;
      ST_LEFT_MUL:    mul_en    = 1'b1;
      ST_RIGHT_MUL:   mul_en    = 1'b1;
      ST_OUT:         res_load  = !res_valid || res.ready;
      default: ;
    endcase
  end

  assign cmd.ready = cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // servo angle clamp and tangent index
  always_comb begin
    ang_ext    = {ang_r[ANG_W-1], ang_r};
    lim_s      = signed'({2'b00, ang_lim_r});
    if (ang_ext > lim_s) begin
      servo_ang = lim_s;
    end else if (ang_ext < -lim_s) begin
      servo_ang = -lim_s;
    end else begin
      servo_ang = ang_ext;
    end
    servo_span = signed'({1'b0, right_lim_r}) - signed'({1'b0, center_r});
    ang_mag    = ang_ext[ANG_W] ? 8'(-ang_ext) : 8'(ang_ext);
    tan_idx    = (ang_mag > 8'(TAN_LAST)) ? TAN_IDX_W'(TAN_LAST) : ang_mag[TAN_IDX_W-1:0];
  end

  // shared multiplier operand select
  always_comb begin
    prod_abs = prod[PROD_W-1] ? -prod : prod;
    mul_a    = '0;
    mul_b    = '0;
    case (state)
      ST_SERVO_MUL: begin
        mul_a = MUL_W'(servo_span);
        mul_b = MUL_W'(servo_ang);
      end
      ST_SERVO_RECIP: begin
        mul_a = MUL_W'(prod_abs[SRV_PROD_W-1:0]);
        mul_b = MUL_W'(RECIP_M);
      end
      ST_RATIO_MUL: begin
        mul_a = MUL_W'(track_r);
        mul_b = MUL_W'(TAN_Q14[tan_idx]);
      end
      ST_LEFT_MUL: begin
        mul_a = MUL_W'(base_r);
        mul_b = ONE_Q - MUL_W'(ratio_r);
      end
      ST_RIGHT_MUL: begin
        mul_a = MUL_W'(base_r);
        mul_b = ONE_Q + MUL_W'(ratio_r);
      end
      default: ;
    endcase
  end

  // shared divider operand select
  always_comb begin
    div_dvd  = '0;
    div_dvs  = DVS_W'(1);
    case (state)
      ST_RATIO_DIV: begin
        div_dvd = {prod[DVD_W-2:0], 1'b0};
        div_dvs = (wbase_r == '0) ? DVS_W'(1) : DVS_W'(wbase_r);
      end
      default: ;
    endcase
  end

  acdd_div #(
    .DVD_W_P (DVD_W),
    .DVS_W_P (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // servo duty: center plus signed scaled quotient, then left and right clamp
  always_comb begin
    q_s     = signed'(SDUTY_W'(prod[RECIP_SH +: SRV_PROD_W]));
    duty    = SDUTY_W'(center_r) + (servo_neg ? -q_s : q_s);
    left_s  = SDUTY_W'(left_lim_r);
    right_s = SDUTY_W'(right_lim_r);
    if (duty < left_s) begin
      duty_clamped = left_lim_r;
    end else if (duty > right_s) begin
      duty_clamped = right_lim_r;
    end else begin
      duty_clamped = duty[DUTY_W-1:0];
    end
  end

  // wheel ratio saturation, and the drive of the wheel being finished
  always_comb begin
    rq    = (div_quo > DVD_W'(R_MAX)) ? R_MAX : div_quo[RQ_W-1:0];
    rq_s  = signed'({1'b0, rq});
    wheel = wheel_drive(prod, motor_lim_r,
                        (state == ST_LEFT_FIN) ? left_dir_held : right_dir_held);
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd_ready) begin
      base_r <= cmd.speed_cmd;
      ang_r  <= cmd.steer_angle;
    end
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (state == ST_SERVO_RECIP) begin
      servo_neg <= prod[PROD_W-1];
    end
    if (state == ST_SERVO_FIN) begin
      servo_duty_r <= duty_clamped;
    end
    if (state == ST_RATIO_WAIT && div_stat.done) begin
      ratio_r <= ang_r[ANG_W-1] ? -rq_s : rq_s;
    end
    if (state == ST_LEFT_FIN) begin
      left_pwm_r <= wheel.pwm;
    end
    if (state == ST_RIGHT_FIN) begin
      right_pwm_r <= wheel.pwm;
    end
  end

  // held direction pins
  always_ff @(posedge clk) begin
    if (rst) begin
      left_dir_held  <= 1'b0;
      right_dir_held <= 1'b0;
    end else begin
      if (state == ST_LEFT_FIN) left_dir_held <= wheel.dir;
      if (state == ST_RIGHT_FIN) right_dir_held <= wheel.dir;
    end
  end

  // output register, result transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_servo <= servo_duty_r;
      res_ldir  <= left_dir_held;
      res_lpwm  <= left_pwm_r;
      res_rdir  <= right_dir_held;
      res_rpwm  <= right_pwm_r;
    end
  end

  assign res.valid      = res_valid;
  assign res.servo_duty = res_servo;
  assign res.left_dir   = res_ldir;
  assign res.left_pwm   = res_lpwm;
  assign res.right_dir  = res_rdir;
  assign res.right_pwm  = res_rpwm;

  // checks
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_cmd_starts_seq: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> (state == ST_SERVO_MUL))
    else $error("command transfer did not start the sequence");

  a_left_within_limit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LEFT_FIN) |=> (left_pwm_r <= $past(motor_lim_r)))
    else $error("left duty above motor limit");

  a_out_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && !res.valid) |=> res.valid)
    else $error("result not offered after completion");

endmodule

`default_nettype wire
